>>> rtl/fsmls_pkg.sv
`timescale 1ns / 1ps

package fsmls_pkg;

  // Field widths fixed by the flit format
  localparam int NODE_ID_BITS  = 8;
  localparam int LATENCY_BITS  = 8;
  localparam int SIZE_BITS     = 5;
  localparam int LEVEL_BITS    = 5;
  localparam int CFG_DATA_BITS = 8;
  localparam int CFG_IDX_BITS  = 3;

  localparam int DEFAULT_FIFO_DEPTH = 16;

  localparam logic [SIZE_BITS-1:0]    RESET_BUFFER_SIZE   = SIZE_BITS'(16);
  localparam logic [SIZE_BITS-1:0]    RESET_PACKET_LENGTH = SIZE_BITS'(4);
  localparam logic [LATENCY_BITS-1:0] RESET_READ_LATENCY  = LATENCY_BITS'(8);
  localparam logic [LATENCY_BITS-1:0] RESET_WRITE_LATENCY = LATENCY_BITS'(8);
  localparam logic [NODE_ID_BITS-1:0] RESET_NODE_ID       = '0;
  localparam logic [LATENCY_BITS-1:0] LATENCY_MAX         = '1;

  typedef enum logic [1:0] {
    FLIT_HEADER   = 2'd0,
    FLIT_BODY     = 2'd1,
    FLIT_TAIL     = 2'd2,
    FLIT_HEADTAIL = 2'd3
  } flit_type_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_HEADER_EARLY = 2'd1,
    ERR_WRONG_DEST   = 2'd2
  } err_code_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BUFFER_SIZE   = 3'd0,
    REG_PACKET_LENGTH = 3'd1,
    REG_READ_LATENCY  = 3'd2,
    REG_WRITE_LATENCY = 3'd3,
    REG_NODE_ID       = 3'd4,
    REG_MEMORY_NODE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                    flit_valid;
    flit_type_t              flit_type;
    logic [NODE_ID_BITS-1:0] dest_id;
    logic                    multicast;
  } in_item_t;

  typedef struct packed {
    logic                  consumed_valid;
    flit_type_t            consumed_type;
    logic                  packet_done;
    logic                  stop;
    err_code_t             error_code;
    logic [LEVEL_BITS-1:0] fifo_level;
  } out_item_t;

  // One stored flit
  typedef struct packed {
    flit_type_t              ftype;
    logic [NODE_ID_BITS-1:0] dest;
    logic                    multi;
  } flit_entry_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]    buffer_size;
    logic [SIZE_BITS-1:0]    packet_length;
    logic [LATENCY_BITS-1:0] read_latency;
    logic [LATENCY_BITS-1:0] write_latency;
    logic [NODE_ID_BITS-1:0] node_id;
    logic                    memory_node;
  } cfg_t;

endpackage

>>> rtl/fsmls_out_buf.sv
`timescale 1ns / 1ps

module fsmls_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fsmls_pkg::out_item_t push_item,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fsmls_pkg::out_item_t out_item
);

  logic                 skid_valid;
  fsmls_pkg::out_item_t skid_item;

  // Ready depends on the skid stage alone, never on the downstream ready
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      // hold the head, park a new item in the skid stage
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (push && !skid_valid) begin
        skid_item <= push_item;
      end
    end else if (skid_valid) begin
      out_item <= skid_item;
    end else if (push) begin
      out_item <= push_item;
    end
  end

endmodule

>>> rtl/flit_sink_with_memory_latency_stall_core.sv
`timescale 1ns / 1ps

// Flit sink for a network endpoint. Every accepted input item is one network
// tick and yields exactly one result item, one item per clock cycle sustained
// while in_ready is high; each result is registered in the output buffer.
// The tick's dequeue, enqueue, flow control, packet tracking and stall update
// are a single combinational pass from the state registers to the result
// register. A two-entry output buffer keeps in_ready independent of
// out_ready, so the input stalls only when two results wait downstream.
// The flit store is held in flip-flops read at the head pointer; its entries
// need no clearing after reset. Configuration is taken on any cycle through
// cfg_we, cfg_index and cfg_data and should only change while the block idles.
module flit_sink_with_memory_latency_stall_core #(
  parameter int FIFO_DEPTH = fsmls_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  fsmls_pkg::in_item_t                   in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output fsmls_pkg::out_item_t                  out_item,
  input  logic                                  cfg_we,
  input  logic [fsmls_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fsmls_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CMP_W = (CNT_W > fsmls_pkg::SIZE_BITS) ? CNT_W : fsmls_pkg::SIZE_BITS;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  fsmls_pkg::cfg_t cfg;

  fsmls_pkg::flit_entry_t store [FIFO_DEPTH];
  logic [CNT_W-1:0]                      store_count, store_count_next;
  logic [PTR_W-1:0]                      rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]                      wr_ptr, wr_ptr_next;
  logic                                  in_packet, in_packet_next;
  logic                                  last_was_read, last_was_read_next;
  logic [fsmls_pkg::LATENCY_BITS-1:0]    stall_count, stall_count_next;
  logic                                  read_enable, read_enable_next;

  logic                                  accept;
  logic                                  push_ready;
  fsmls_pkg::out_item_t                  result;

  logic                                  got;
  fsmls_pkg::flit_entry_t                head;
  logic [CNT_W-1:0]                      count_deq;
  logic                                  enq;
  logic [CMP_W-1:0]                      level_ext;
  logic [CMP_W-1:0]                      size_ext;
  logic [CMP_W-1:0]                      free_space;
  logic                                  is_head;
  logic                                  done;
  fsmls_pkg::err_code_t                  err;
  logic [fsmls_pkg::LATENCY_BITS-1:0]    stall_mid;
  logic                                  read_mid;
  logic [fsmls_pkg::LATENCY_BITS-1:0]    lat;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_size   <= fsmls_pkg::RESET_BUFFER_SIZE;
      cfg.packet_length <= fsmls_pkg::RESET_PACKET_LENGTH;
      cfg.read_latency  <= fsmls_pkg::RESET_READ_LATENCY;
      cfg.write_latency <= fsmls_pkg::RESET_WRITE_LATENCY;
      cfg.node_id       <= fsmls_pkg::RESET_NODE_ID;
      cfg.memory_node   <= 1'b0;
    end else if (cfg_we) begin
      unique case (fsmls_pkg::cfg_reg_t'(cfg_index))
        fsmls_pkg::REG_BUFFER_SIZE:
          cfg.buffer_size <= cfg_data[fsmls_pkg::SIZE_BITS-1:0];
        fsmls_pkg::REG_PACKET_LENGTH:
          cfg.packet_length <= cfg_data[fsmls_pkg::SIZE_BITS-1:0];
        fsmls_pkg::REG_READ_LATENCY:
          cfg.read_latency <= cfg_data[fsmls_pkg::LATENCY_BITS-1:0];
        fsmls_pkg::REG_WRITE_LATENCY:
          cfg.write_latency <= cfg_data[fsmls_pkg::LATENCY_BITS-1:0];
        fsmls_pkg::REG_NODE_ID:
          cfg.node_id <= cfg_data[fsmls_pkg::NODE_ID_BITS-1:0];
        fsmls_pkg::REG_MEMORY_NODE:
          cfg.memory_node <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One tick of the sink
  always_comb begin
    // dequeue
    got       = read_enable && (store_count != '0);
    head      = store[rd_ptr];
    count_deq = store_count - CNT_W'(got);
    rd_ptr_next = rd_ptr;
    if (got) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
    end

    // enqueue; drop when full after the dequeue
    enq              = in_item.flit_valid && (count_deq != CNT_FULL);
    store_count_next = count_deq + CNT_W'(enq);
    wr_ptr_next      = wr_ptr;
    if (enq) begin
      wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
    end

    // cut-through flow control
    level_ext  = CMP_W'(store_count_next);
    size_ext   = CMP_W'(cfg.buffer_size);
    free_space = (size_ext > level_ext) ? size_ext - level_ext : '0;

    // packet tracking of the dequeued flit
    is_head            = (head.ftype == fsmls_pkg::FLIT_HEADER) ||
                         (head.ftype == fsmls_pkg::FLIT_HEADTAIL);
    done               = 1'b0;
    err                = fsmls_pkg::ERR_NONE;
    in_packet_next     = in_packet;
    stall_mid          = stall_count;
    read_mid           = last_was_read;
    if (got) begin
      if (in_packet && is_head) begin
        err = fsmls_pkg::ERR_HEADER_EARLY;
      end else if (!in_packet && (head.dest != cfg.node_id) && !head.multi) begin
        err = fsmls_pkg::ERR_WRONG_DEST;
      end else begin
        if (!in_packet) begin
          in_packet_next = (head.ftype != fsmls_pkg::FLIT_HEADTAIL);
          if (head.ftype == fsmls_pkg::FLIT_HEADTAIL) begin
            done = 1'b1;
            if (cfg.memory_node) begin
              read_mid  = 1'b1;
              stall_mid = '0;
            end
          end
        end
        if (head.ftype == fsmls_pkg::FLIT_TAIL) begin
          done           = 1'b1;
          in_packet_next = 1'b0;
          if (cfg.memory_node) begin
            read_mid  = 1'b0;
            stall_mid = '0;
          end
        end
      end
    end

    // memory latency stall, saturating counter
    last_was_read_next = read_mid;
    lat                = read_mid ? cfg.read_latency : cfg.write_latency;
    stall_count_next   = stall_mid;
    read_enable_next   = 1'b1;
    if (cfg.memory_node) begin
      if (stall_mid != fsmls_pkg::LATENCY_MAX) begin
        stall_count_next = stall_mid + fsmls_pkg::LATENCY_BITS'(1);
      end
      read_enable_next = (stall_count_next >= lat);
    end

    result.consumed_valid = got;
    result.consumed_type  = got ? head.ftype : fsmls_pkg::FLIT_HEADER;
    result.packet_done    = done;
    result.stop           = (free_space <= CMP_W'(cfg.packet_length));
    result.error_code     = err;
    result.fifo_level     = level_ext[fsmls_pkg::LEVEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_count   <= '0;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      in_packet     <= 1'b0;
      last_was_read <= 1'b1;
      stall_count   <= fsmls_pkg::RESET_READ_LATENCY;
      read_enable   <= 1'b1;
    end else if (accept) begin
      store_count   <= store_count_next;
      rd_ptr        <= rd_ptr_next;
      wr_ptr        <= wr_ptr_next;
      in_packet     <= in_packet_next;
      last_was_read <= last_was_read_next;
      stall_count   <= stall_count_next;
      read_enable   <= read_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && enq) begin
      store[wr_ptr] <= '{ftype: in_item.flit_type, dest: in_item.dest_id,
                         multi: in_item.multicast};
    end
  end

  fsmls_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_item  (result),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    store_count <= CNT_FULL)
    else $error("flit store count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(store_count) && $stable(rd_ptr) && $stable(wr_ptr))
    else $error("flit store moved without an item");

  a_plain_node_reads: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg.memory_node |=> read_enable)
    else $error("reading held off on a plain node");

  a_done_restarts_stall: assert property (@(posedge clk) disable iff (rst)
    accept && cfg.memory_node && done |=>
      stall_count == fsmls_pkg::LATENCY_BITS'(1))
    else $error("stall counter not restarted on packet completion");

  a_error_no_done: assert property (@(posedge clk) disable iff (rst)
    accept && (err != fsmls_pkg::ERR_NONE) |=> $stable(in_packet))
    else $error("dropped flit changed packet state");

endmodule

>>> bench/tb_flit_sink_with_memory_latency_stall_core.sv
`timescale 1ns / 1ps

module tb_flit_sink_with_memory_latency_stall_core;
  import fsmls_pkg::*;

  localparam int DEPTH = DEFAULT_FIFO_DEPTH;
  localparam int QUIET_LIMIT = 1000;

  typedef enum logic [1:0] {
    ROW_FLIT,
    ROW_KNOWN,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t               kind;
    in_item_t                flit;
    out_item_t               want;
    cfg_reg_t                reg_idx;
    logic [CFG_DATA_BITS-1:0] value;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  flit_sink_with_memory_latency_stall_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the sink: registers and buffer state
  cfg_t regs;
  flit_entry_t slot [DEPTH];
  logic [LEVEL_BITS-1:0] held;
  logic [3:0] rd_ptr;
  logic [3:0] wr_ptr;
  logic open_pkt;
  logic was_read;
  logic [LATENCY_BITS-1:0] stall_ticks;
  logic rd_on;

  out_item_t ticks_due [$];
  in_item_t pending_flits [$];
  dir_row_t dir_rows [$];
  int faults = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  bit cfg_open = 1'b0;
  out_item_t head_due;

  function automatic void reset_model();
    regs = '{buffer_size: RESET_BUFFER_SIZE, packet_length: RESET_PACKET_LENGTH,
             read_latency: RESET_READ_LATENCY, write_latency: RESET_WRITE_LATENCY,
             node_id: RESET_NODE_ID, memory_node: 1'b0};
    held = '0;
    rd_ptr = '0;
    wr_ptr = '0;
    open_pkt = 1'b0;
    was_read = 1'b1;
    stall_ticks = RESET_READ_LATENCY;
    rd_on = 1'b1;
  endfunction

  // One network tick: dequeue, enqueue, flow control, packet tracking, stall
  function automatic out_item_t sink_tick(input in_item_t f);
    flit_entry_t head;
    logic got;
    logic done;
    logic stop;
    err_code_t err;
    logic [SIZE_BITS-1:0] room;
    logic [LATENCY_BITS-1:0] lat;
    got = 1'b0;
    done = 1'b0;
    err = ERR_NONE;
    head = '0;
    if (rd_on && held != 0) begin
      head = slot[rd_ptr];
      got = 1'b1;
      rd_ptr = rd_ptr + 4'd1;
      held = held - 1'b1;
    end
    if (f.flit_valid && held < DEPTH) begin
      slot[wr_ptr] = '{ftype: f.flit_type, dest: f.dest_id, multi: f.multicast};
      wr_ptr = wr_ptr + 4'd1;
      held = held + 1'b1;
    end
    room = (regs.buffer_size > held) ? regs.buffer_size - held : '0;
    stop = (room <= regs.packet_length);
    if (got) begin
      if (open_pkt && (head.ftype == FLIT_HEADER || head.ftype == FLIT_HEADTAIL)) begin
        err = ERR_HEADER_EARLY;
      end else if (!open_pkt && head.dest != regs.node_id && !head.multi) begin
        err = ERR_WRONG_DEST;
      end else begin
        if (!open_pkt) begin
          open_pkt = (head.ftype != FLIT_HEADTAIL);
          if (head.ftype == FLIT_HEADTAIL) begin
            done = 1'b1;
            if (regs.memory_node) begin
              was_read = 1'b1;
              stall_ticks = '0;
            end
          end
        end
        if (head.ftype == FLIT_TAIL) begin
          done = 1'b1;
          open_pkt = 1'b0;
          if (regs.memory_node) begin
            was_read = 1'b0;
            stall_ticks = '0;
          end
        end
      end
    end
    if (regs.memory_node) begin
      lat = was_read ? regs.read_latency : regs.write_latency;
      if (stall_ticks != LATENCY_MAX) stall_ticks = stall_ticks + 1'b1;
      rd_on = (stall_ticks >= lat);
    end else begin
      rd_on = 1'b1;
    end
    return '{consumed_valid: got, consumed_type: head.ftype, packet_done: done,
             stop: stop, error_code: err, fifo_level: held};
  endfunction

  function automatic in_item_t flit_of(input logic v, input flit_type_t t,
                                       input logic [NODE_ID_BITS-1:0] d, input logic m);
    return '{flit_valid: v, flit_type: t, dest_id: d, multicast: m};
  endfunction

  function automatic out_item_t result_of(input logic cv, input flit_type_t t, input logic done,
                                          input logic stop, input err_code_t e,
                                          input logic [LEVEL_BITS-1:0] lvl);
    return '{consumed_valid: cv, consumed_type: t, packet_done: done, stop: stop,
             error_code: e, fifo_level: lvl};
  endfunction

  function automatic void known_row(input in_item_t f, input out_item_t want);
    dir_rows.push_back('{kind: ROW_KNOWN, flit: f, want: want, reg_idx: REG_BUFFER_SIZE,
                         value: '0});
  endfunction

  function automatic void flit_row(input in_item_t f);
    dir_rows.push_back('{kind: ROW_FLIT, flit: f, want: '0, reg_idx: REG_BUFFER_SIZE,
                         value: '0});
  endfunction

  function automatic void reg_row(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] v);
    dir_rows.push_back('{kind: ROW_REG, flit: '0, want: '0, reg_idx: idx, value: v});
  endfunction

  function automatic flit_type_t any_type();
    return flit_type_t'($urandom_range(3));
  endfunction

  // Queue up the next stretch of random traffic, mostly well-formed packets
  function automatic void plan_packet();
    int kind;
    int len;
    logic [NODE_ID_BITS-1:0] hdest;
    flit_type_t ft;
    kind = $urandom_range(99);
    hdest = ($urandom_range(99) < 85) ? regs.node_id : NODE_ID_BITS'($urandom);
    if (kind < 70) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        if (len == 1) ft = FLIT_HEADTAIL;
        else if (k == 0) ft = FLIT_HEADER;
        else if (k == len - 1) ft = FLIT_TAIL;
        else ft = FLIT_BODY;
        if (k == 0) begin
          pending_flits.push_back(flit_of(1'b1, ft, hdest, $urandom_range(99) < 20));
        end else begin
          pending_flits.push_back(flit_of(1'b1, ft, NODE_ID_BITS'($urandom),
                                          1'($urandom_range(1))));
        end
        if ($urandom_range(99) < 12) begin
          pending_flits.push_back(flit_of(1'b0, any_type(), NODE_ID_BITS'($urandom),
                                          1'($urandom_range(1))));
        end
      end
    end else if (kind < 88) begin
      len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
        pending_flits.push_back(flit_of(1'b1, any_type(), hdest, 1'($urandom_range(1))));
      end
    end else begin
      pending_flits.push_back(flit_of(1'($urandom_range(1)), any_type(),
                                      NODE_ID_BITS'($urandom), 1'($urandom_range(1))));
    end
  endfunction

  task automatic offer_flit(input in_item_t f, input bit known, input out_item_t want);
    out_item_t predicted;
    bit lowered;
    lowered = 1'b0;
    while (!steady && $urandom_range(99) < 23) begin
      if (!lowered) in_valid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= f;
    do @(posedge clk); while (!in_ready);
    predicted = sink_tick(f);
    ticks_due.push_back(known ? want : predicted);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (ticks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_BUFFER_SIZE:   regs.buffer_size = v[SIZE_BITS-1:0];
      REG_PACKET_LENGTH: regs.packet_length = v[SIZE_BITS-1:0];
      REG_READ_LATENCY:  regs.read_latency = v[LATENCY_BITS-1:0];
      REG_WRITE_LATENCY: regs.write_latency = v[LATENCY_BITS-1:0];
      REG_NODE_ID:       regs.node_id = v[NODE_ID_BITS-1:0];
      REG_MEMORY_NODE:   regs.memory_node = v[0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input cfg_t c);
    settle();
    write_reg(REG_BUFFER_SIZE, CFG_DATA_BITS'(c.buffer_size));
    write_reg(REG_PACKET_LENGTH, CFG_DATA_BITS'(c.packet_length));
    write_reg(REG_READ_LATENCY, c.read_latency);
    write_reg(REG_WRITE_LATENCY, c.write_latency);
    write_reg(REG_NODE_ID, c.node_id);
    write_reg(REG_MEMORY_NODE, CFG_DATA_BITS'(c.memory_node));
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (ticks_due.size() == 0) begin
        if (faults < 10) $display("%0t: result item with nothing outstanding", $realtime);
        faults++;
      end else begin
        head_due = ticks_due.pop_front();
        if (head_due.consumed_valid !== out_item.consumed_valid
            || head_due.consumed_type !== out_item.consumed_type
            || head_due.packet_done !== out_item.packet_done
            || head_due.stop !== out_item.stop
            || head_due.error_code !== out_item.error_code
            || head_due.fifo_level !== out_item.fifo_level) begin
          if (faults < 10) begin
            $display("%0t: mismatch want cv=%0d type=%0d done=%0d stop=%0d err=%0d lvl=%0d",
                     $realtime, head_due.consumed_valid, head_due.consumed_type,
                     head_due.packet_done, head_due.stop, head_due.error_code,
                     head_due.fifo_level);
            $display("%0t:          got  cv=%0d type=%0d done=%0d stop=%0d err=%0d lvl=%0d",
                     $realtime, out_item.consumed_valid, out_item.consumed_type,
                     out_item.packet_done, out_item.stop, out_item.error_code,
                     out_item.fifo_level);
          end
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_flit_sink_with_memory_latency_stall_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    cfg_t settings [6];
    int counts [6];
    in_item_t nf;
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: node 0, plain node
    known_row(flit_of(1'b0, FLIT_HEADER, 8'h00, 1'b0),
              result_of(1'b0, FLIT_HEADER, 1'b0, 1'b0, ERR_NONE, 5'd0));
    known_row(flit_of(1'b1, FLIT_HEADTAIL, 8'h00, 1'b0),
              result_of(1'b0, FLIT_HEADER, 1'b0, 1'b0, ERR_NONE, 5'd1));
    known_row(flit_of(1'b1, FLIT_HEADER, 8'hFF, 1'b0),
              result_of(1'b1, FLIT_HEADTAIL, 1'b1, 1'b0, ERR_NONE, 5'd1));
    known_row(flit_of(1'b1, FLIT_BODY, 8'hFF, 1'b0),
              result_of(1'b1, FLIT_HEADER, 1'b0, 1'b0, ERR_WRONG_DEST, 5'd1));
    known_row(flit_of(1'b1, FLIT_TAIL, 8'h00, 1'b1),
              result_of(1'b1, FLIT_BODY, 1'b0, 1'b0, ERR_WRONG_DEST, 5'd1));
    known_row(flit_of(1'b1, FLIT_HEADER, 8'h55, 1'b1),
              result_of(1'b1, FLIT_TAIL, 1'b1, 1'b0, ERR_NONE, 5'd1));
    known_row(flit_of(1'b1, FLIT_HEADER, 8'hAA, 1'b0),
              result_of(1'b1, FLIT_HEADER, 1'b0, 1'b0, ERR_NONE, 5'd1));
    known_row(flit_of(1'b1, FLIT_HEADTAIL, 8'h00, 1'b0),
              result_of(1'b1, FLIT_HEADER, 1'b0, 1'b0, ERR_HEADER_EARLY, 5'd1));
    known_row(flit_of(1'b1, FLIT_BODY, 8'hAA, 1'b0),
              result_of(1'b1, FLIT_HEADTAIL, 1'b0, 1'b0, ERR_HEADER_EARLY, 5'd1));
    known_row(flit_of(1'b1, FLIT_TAIL, 8'h33, 1'b0),
              result_of(1'b1, FLIT_BODY, 1'b0, 1'b0, ERR_NONE, 5'd1));
    known_row(flit_of(1'b0, FLIT_TAIL, 8'hFF, 1'b1),
              result_of(1'b1, FLIT_TAIL, 1'b1, 1'b0, ERR_NONE, 5'd0));
    // Memory node with the longest read stall: fill the store past full,
    // with the level well beyond a one-entry buffer
    reg_row(REG_MEMORY_NODE, 8'd1);
    reg_row(REG_READ_LATENCY, 8'd255);
    reg_row(REG_WRITE_LATENCY, 8'd0);
    reg_row(REG_BUFFER_SIZE, 8'd1);
    reg_row(REG_PACKET_LENGTH, 8'd1);
    reg_row(REG_NODE_ID, 8'hFF);
    for (int k = 0; k < 17; k++) begin
      flit_row(flit_of(1'b1, flit_type_t'(k[1:0]), 8'hFF, k[0]));
    end

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!cfg_open) settle();
        cfg_open = 1'b1;
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        if (cfg_open) cfg_we <= 1'b0;
        cfg_open = 1'b0;
        offer_flit(dir_rows[i].flit, dir_rows[i].kind == ROW_KNOWN, dir_rows[i].want);
      end
    end

    settings[0] = '{buffer_size: 5'd16, packet_length: 5'd4, read_latency: 8'd8,
                    write_latency: 8'd8, node_id: 8'($urandom), memory_node: 1'b0};
    settings[1] = '{buffer_size: 5'd16, packet_length: 5'd1, read_latency: 8'd0,
                    write_latency: 8'd0, node_id: 8'hFF, memory_node: 1'b1};
    settings[2] = '{buffer_size: 5'd8, packet_length: 5'd2, read_latency: 8'd3,
                    write_latency: 8'd12, node_id: 8'($urandom), memory_node: 1'b1};
    settings[3] = '{buffer_size: 5'd1, packet_length: 5'd16, read_latency: 8'($urandom),
                    write_latency: 8'($urandom), node_id: 8'h00, memory_node: 1'b0};
    settings[4] = '{buffer_size: 5'd16, packet_length: 5'd16, read_latency: 8'd40,
                    write_latency: 8'd255, node_id: 8'($urandom), memory_node: 1'b1};
    settings[5] = '{buffer_size: 5'($urandom_range(1, 16)),
                    packet_length: 5'($urandom_range(1, 16)),
                    read_latency: 8'($urandom_range(0, 20)),
                    write_latency: 8'($urandom_range(0, 20)),
                    node_id: 8'($urandom), memory_node: 1'b1};
    counts = '{35, 35, 35, 35, 250, 35};

    for (int p = 0; p < 6; p++) begin
      load_setting(settings[p]);
      pending_flits.delete();
      steady = (p == 1);
      for (int n = 0; n < counts[p]; n++) begin
        // hold off mid-phase until the sink has answered everything
        if (p == 2 && n == 20) settle();
        if (pending_flits.size() == 0) plan_packet();
        nf = pending_flits.pop_front();
        offer_flit(nf, 1'b0, '0);
      end
    end
    steady = 1'b0;

    settle();
    if (faults == 0) begin
      $display("tb_flit_sink_with_memory_latency_stall_core: done, clean");
    end else begin
      $display("tb_flit_sink_with_memory_latency_stall_core: done, errors");
    end
    $finish;
  end

endmodule
